### hdl/lsah_pkg.sv
// ============================================================================
// lsah_pkg
// Shared types and constants of the limit switch averaging block: run modes,
// control states, configuration register indexes and reset values.
// ============================================================================
`default_nettype none

package lsah_pkg;

	// Field widths
	localparam int SAMPLE_BITS_DEF = 12;
	localparam int THRESH_BITS     = 12;
	localparam int COUNT_BITS      = 8;
	localparam int CFG_INDEX_BITS  = 2;
	localparam int CFG_DATA_BITS   = 12;

	// Configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] CFG_RELEASE = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_PRESS   = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW  = 2'd2;

	// Register reset values
	localparam logic [THRESH_BITS-1:0] RELEASE_RST = 12'd2500;
	localparam logic [THRESH_BITS-1:0] PRESS_RST   = 12'd1000;
	localparam logic [COUNT_BITS-1:0]  WINDOW_RST  = 8'd50;

	// Run mode reported on the mode output
	typedef enum logic [1:0] {
		MODE_CALIB = 2'd0,
		MODE_SWEEP = 2'd1,
		MODE_STOP  = 2'd2
	} mode_t;

	// Top level control
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_PUB
	} state_t;

	// Mean unit phases
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_MUL,
		PH_LOAD,
		PH_DIV,
		PH_DONE
	} phase_t;

endpackage

`default_nettype wire

### hdl/lsah_mean.sv
// ============================================================================
// lsah_mean
// Running mean update (old*n + x)/(n+1), truncated. Shift-add multiply, one
// count bit per cycle, then restoring divide, one quotient bit per cycle.
// ============================================================================
`default_nettype none

module lsah_mean #(
	parameter int SAMPLE_BITS = lsah_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [SAMPLE_BITS-1:0]          old_mean,
	input  wire logic [SAMPLE_BITS-1:0]          sample,
	input  wire logic [lsah_pkg::COUNT_BITS-1:0] count,
	output logic                                 done,
	output logic [SAMPLE_BITS-1:0]               mean
);

	localparam int NB = lsah_pkg::COUNT_BITS;
	localparam int DW = NB + 1;                 // divisor n+1
	localparam int PW = SAMPLE_BITS + NB + 1;   // old*n + x
	localparam int CW = $clog2(SAMPLE_BITS);

	lsah_pkg::phase_t phase_q, phase_d;
	logic [CW-1:0]          cnt_q;
	logic [PW-1:0]          prod_q;
	logic [PW-1:0]          mcand_q;
	logic [NB-1:0]          mplier_q;
	logic [DW-1:0]          div_q;
	logic [DW-1:0]          rem_q;
	logic [SAMPLE_BITS-1:0] low_q;
	logic [DW:0]            trial;
	logic [DW:0]            diff;
	logic                   ge;

	// Phase sequencing
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			lsah_pkg::PH_IDLE: begin
				if (start) phase_d = lsah_pkg::PH_MUL;
			end
			lsah_pkg::PH_MUL: begin
				if (cnt_q == CW'(NB - 1)) phase_d = lsah_pkg::PH_LOAD;
			end
			lsah_pkg::PH_LOAD: begin
				phase_d = lsah_pkg::PH_DIV;
			end
			lsah_pkg::PH_DIV: begin
				if (cnt_q == CW'(SAMPLE_BITS - 1)) phase_d = lsah_pkg::PH_DONE;
			end
			lsah_pkg::PH_DONE: begin
				phase_d = lsah_pkg::PH_IDLE;
			end
			default: begin
				phase_d = lsah_pkg::PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lsah_pkg::PH_IDLE;
			cnt_q   <= '0;
		end else begin
			phase_q <= phase_d;
			if (phase_d != phase_q) cnt_q <= '0;
			else cnt_q <= cnt_q + CW'(1);
		end
	end

	// Restoring divide step: partial remainder stays below the divisor
	assign trial = {rem_q, low_q[SAMPLE_BITS-1]};
	assign diff  = trial - (DW + 1)'(div_q);
	assign ge    = (trial >= (DW + 1)'(div_q));

	// Datapath shift registers
	always_ff @(posedge clk) begin
		case (phase_q)
			lsah_pkg::PH_IDLE: begin
				if (start) begin
					prod_q   <= PW'(sample);
					mcand_q  <= PW'(old_mean);
					mplier_q <= count;
					div_q    <= DW'(count) + DW'(1);
				end
			end
			lsah_pkg::PH_MUL: begin
				if (mplier_q[0]) prod_q <= prod_q + mcand_q;
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
			end
			lsah_pkg::PH_LOAD: begin
				rem_q <= prod_q[PW-1:SAMPLE_BITS];
				low_q <= prod_q[SAMPLE_BITS-1:0];
			end
			lsah_pkg::PH_DIV: begin
				rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
				low_q <= {low_q[SAMPLE_BITS-2:0], ge};
			end
			default: begin
			end
		endcase
	end

	assign done = (phase_q == lsah_pkg::PH_DONE);
	assign mean = low_q;

endmodule

`default_nettype wire

### hdl/limit_switch_average_hysteresis.sv
// ============================================================================
// limit_switch_average_hysteresis
// Averages the security and calibration switch lines over a window, applies
// hysteresis to each mean and supervises the calibrate/sweep/stop mode.
// ============================================================================
// Usage:
//  - Input channel (in_valid/in_ready) carries one sample pair plus the
//    positioned and start_calibration bits. Output channel (out_valid/
//    out_ready) returns one result per input transfer: mode, both flags,
//    window_done, trip and both running means.
//  - An item passes from input transfer to out_valid through a shift-add
//    multiply by the count, one bit per cycle, a load step, a restoring
//    divide by count+1, one quotient bit per cycle, a commit step and the
//    fill of the output register. Both lines run in parallel units. One item
//    is in flight at a time; a new input is taken only after the previous
//    result has been loaded into the output register.
//  - Configuration: cfg_write with cfg_index/cfg_data writes a register;
//    write only while no item is in flight.
//  - Reset clears the means, count, flags and mode (calibrating) and loads
//    the default thresholds and window.
//  - When the receiver stalls, the result holds in the output register; one
//    more item may be taken and computed, and it then waits until the held
//    transfer completes before the next input is taken.
//  - Safety stop latches until reset.
// ============================================================================
`default_nettype none

module limit_switch_average_hysteresis #(
	parameter int SAMPLE_BITS = lsah_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// configuration
	input  wire logic                                cfg_write,
	input  wire logic [lsah_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [lsah_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	// input channel
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [SAMPLE_BITS-1:0]              security_sample,
	input  wire logic [SAMPLE_BITS-1:0]              calib_sample,
	input  wire logic                                positioned,
	input  wire logic                                start_calibration,
	// output channel
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [1:0]                               mode,
	output logic                                     security_ok,
	output logic                                     calib_ok,
	output logic                                     window_done,
	output logic                                     trip,
	output logic [SAMPLE_BITS-1:0]                   security_mean,
	output logic [SAMPLE_BITS-1:0]                   calib_mean
);

	localparam int NB   = lsah_pkg::COUNT_BITS;
	localparam int TB   = lsah_pkg::THRESH_BITS;
	localparam int CMPW = (SAMPLE_BITS > TB) ? SAMPLE_BITS : TB;

	// Configuration registers
	logic [TB-1:0] release_q;
	logic [TB-1:0] press_q;
	logic [NB-1:0] window_q;

	// Block state
	lsah_pkg::state_t state_q, state_d;
	lsah_pkg::mode_t  run_mode_q, mode_acc, mode_sec, mode_new;
	logic [NB-1:0]          sample_count_q;
	logic [SAMPLE_BITS-1:0] sec_avg_q, cal_avg_q;
	logic                   sec_flag_q, cal_flag_q;
	logic [NB-1:0]          n_q;
	logic                   positioned_q;
	logic                   done_q, trip_q;

	// Output register
	logic                   out_valid_q;
	lsah_pkg::mode_t        out_mode_q;
	logic                   out_sec_ok_q, out_cal_ok_q, out_done_q, out_trip_q;
	logic [SAMPLE_BITS-1:0] out_sec_mean_q, out_cal_mean_q;

	// Datapath
	logic                   in_xfer, load_out, commit;
	logic [NB-1:0]          win_eff, n_start, count_inc;
	logic                   win_hit;
	logic                   sec_done, cal_done;
	logic [SAMPLE_BITS-1:0] sec_new, cal_new;
	logic                   sec_flag_new, cal_flag_new;
	logic                   sec_pressed, cal_pressed, trip_new;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			release_q <= lsah_pkg::RELEASE_RST;
			press_q   <= lsah_pkg::PRESS_RST;
			window_q  <= lsah_pkg::WINDOW_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				lsah_pkg::CFG_RELEASE: release_q <= cfg_data[TB-1:0];
				lsah_pkg::CFG_PRESS:   press_q   <= cfg_data[TB-1:0];
				lsah_pkg::CFG_WINDOW:  window_q  <= cfg_data[NB-1:0];
				default: begin
				end
			endcase
		end
	end

	// Window bookkeeping; a zero window acts as one
	assign win_eff   = (window_q == '0) ? NB'(1) : window_q;
	assign n_start   = (sample_count_q >= win_eff) ? '0 : sample_count_q;
	assign count_inc = n_q + NB'(1);
	assign win_hit   = (count_inc >= win_eff);

	// start_calibration applies before the means update
	always_comb begin
		mode_acc = run_mode_q;
		if (start_calibration && run_mode_q != lsah_pkg::MODE_STOP)
			mode_acc = lsah_pkg::MODE_CALIB;
	end

	// Mean units, one per line, started together
	lsah_mean #(.SAMPLE_BITS(SAMPLE_BITS)) u_sec_mean (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_xfer),
		.old_mean (sec_avg_q),
		.sample   (security_sample),
		.count    (n_start),
		.done     (sec_done),
		.mean     (sec_new)
	);

	lsah_mean #(.SAMPLE_BITS(SAMPLE_BITS)) u_cal_mean (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_xfer),
		.old_mean (cal_avg_q),
		.sample   (calib_sample),
		.count    (n_start),
		.done     (cal_done),
		.mean     (cal_new)
	);

	// Hysteresis: release test first, press test wins
	always_comb begin
		sec_flag_new = sec_flag_q;
		cal_flag_new = cal_flag_q;
		sec_pressed  = 1'b0;
		cal_pressed  = 1'b0;
		if (win_hit) begin
			if (CMPW'(sec_new) > CMPW'(release_q)) sec_flag_new = 1'b1;
			if (CMPW'(sec_new) < CMPW'(press_q)) begin
				sec_flag_new = 1'b0;
				sec_pressed  = 1'b1;
			end
			if (CMPW'(cal_new) > CMPW'(release_q)) cal_flag_new = 1'b1;
			if (CMPW'(cal_new) < CMPW'(press_q)) begin
				cal_flag_new = 1'b0;
				cal_pressed  = 1'b1;
			end
		end
	end

	// Mode transitions: security line before calibration line
	always_comb begin
		trip_new = 1'b0;
		mode_sec = run_mode_q;
		if (sec_pressed && run_mode_q == lsah_pkg::MODE_SWEEP && positioned_q) begin
			mode_sec = lsah_pkg::MODE_STOP;
			trip_new = 1'b1;
		end
		mode_new = mode_sec;
		if (cal_pressed && mode_sec == lsah_pkg::MODE_CALIB)
			mode_new = lsah_pkg::MODE_SWEEP;
	end

	// Control next state
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		load_out = 1'b0;
		commit   = 1'b0;
		case (state_q)
			lsah_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = lsah_pkg::ST_CALC;
			end
			lsah_pkg::ST_CALC: begin
				if (sec_done) begin
					commit  = 1'b1;
					state_d = lsah_pkg::ST_PUB;
				end
			end
			lsah_pkg::ST_PUB: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = lsah_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lsah_pkg::ST_IDLE;
			end
		endcase
	end

	assign in_xfer = in_valid && in_ready;

	// State update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= lsah_pkg::ST_IDLE;
			run_mode_q     <= lsah_pkg::MODE_CALIB;
			sample_count_q <= '0;
			sec_avg_q      <= '0;
			cal_avg_q      <= '0;
			sec_flag_q     <= 1'b0;
			cal_flag_q     <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_xfer) run_mode_q <= mode_acc;
			if (commit) begin
				run_mode_q     <= mode_new;
				sample_count_q <= win_hit ? '0 : count_inc;
				sec_avg_q      <= sec_new;
				cal_avg_q      <= cal_new;
				sec_flag_q     <= sec_flag_new;
				cal_flag_q     <= cal_flag_new;
			end
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Per-item payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			n_q          <= n_start;
			positioned_q <= positioned;
		end
		if (commit) begin
			done_q <= win_hit;
			trip_q <= trip_new;
		end
		if (load_out) begin
			out_mode_q     <= run_mode_q;
			out_sec_ok_q   <= sec_flag_q;
			out_cal_ok_q   <= cal_flag_q;
			out_done_q     <= done_q;
			out_trip_q     <= trip_q;
			out_sec_mean_q <= sec_avg_q;
			out_cal_mean_q <= cal_avg_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign mode          = out_mode_q;
	assign security_ok   = out_sec_ok_q;
	assign calib_ok      = out_cal_ok_q;
	assign window_done   = out_done_q;
	assign trip          = out_trip_q;
	assign security_mean = out_sec_mean_q;
	assign calib_mean    = out_cal_mean_q;

	// Checks
	a_stop_latched: assert property (@(posedge clk) disable iff (!arst_n)
		(run_mode_q == lsah_pkg::MODE_STOP) |=> (run_mode_q == lsah_pkg::MODE_STOP))
		else $error("safety stop left before reset");

	a_units_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		sec_done == cal_done)
		else $error("mean units out of step");

	a_trip_in_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && trip) |-> (mode == lsah_pkg::MODE_STOP))
		else $error("trip reported outside safety stop");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sec_done |-> !in_ready)
		else $error("input taken while mean units busy");

endmodule

`default_nettype wire

### bench/tb_top.sv
// ============================================================================
// tb_top
// Self-checking bench for limit_switch_average_hysteresis. Sample pairs go in
// over the valid/ready input channel. A local model of the running means, the
// hysteresis flags and the run mode predicts every result. Results are checked
// field by field as they come out, in order. Directed cases cover field
// extremes, threshold edges, crossed thresholds, a zero window, a window
// shortened mid-count and the safety stop latch. Random windows follow under
// several register settings, with random gaps on both channels.
// ============================================================================

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SB         = lsah_pkg::SAMPLE_BITS_DEF;
	localparam int SAMPLE_MAX = (1 << SB) - 1;
	localparam int STALL_MAX  = 2000;     // cycles with no transfer before giving up
	localparam int TAIL_WAIT  = 30;       // wait after the last pending result is taken
	localparam int LOG_MAX    = 50;       // mismatch lines shown, all are counted
	localparam logic [lsah_pkg::CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;

	typedef logic [SB-1:0] sample_t;

	typedef struct packed {
		lsah_pkg::mode_t mode;
		logic            security_ok;
		logic            calib_ok;
		logic            window_done;
		logic            trip;
		sample_t         security_mean;
		sample_t         calib_mean;
	} switch_report_t;

	// DUT connections
	logic                                clk;
	logic                                arst_n;
	logic                                cfg_write;
	logic [lsah_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	logic [lsah_pkg::CFG_DATA_BITS-1:0]  cfg_data;
	logic                                in_valid;
	logic                                in_ready;
	sample_t                             security_sample;
	sample_t                             calib_sample;
	logic                                positioned;
	logic                                start_calibration;
	logic                                out_valid;
	logic                                out_ready;
	logic [1:0]                          mode;
	logic                                security_ok;
	logic                                calib_ok;
	logic                                window_done;
	logic                                trip;
	sample_t                             security_mean;
	sample_t                             calib_mean;

	// Model registers and state
	logic [11:0]     rel_thresh;
	logic [11:0]     prs_thresh;
	logic [7:0]      win_len;
	logic [7:0]      m_count;
	sample_t         m_sec_avg;
	sample_t         m_cal_avg;
	logic            m_sec_flag;
	logic            m_cal_flag;
	lsah_pkg::mode_t m_mode;

	switch_report_t reports_due[$];

	bit quiet;
	int errors;
	int pairs_sent;
	int reports_checked;
	int windows_seen;
	int sweep_entries;
	int trips_seen;
	int idle_cycles;

	limit_switch_average_hysteresis u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write         (cfg_write),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.security_sample   (security_sample),
		.calib_sample      (calib_sample),
		.positioned        (positioned),
		.start_calibration (start_calibration),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.mode              (mode),
		.security_ok       (security_ok),
		.calib_ok          (calib_ok),
		.window_done       (window_done),
		.trip              (trip),
		.security_mean     (security_mean),
		.calib_mean        (calib_mean)
	);

	// 2 ns clock
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// ------------------------------------------------------------------------
	// Model
	// ------------------------------------------------------------------------

	// Truncated running mean with n samples already in the window
	function automatic sample_t next_mean(sample_t old, logic [7:0] n, sample_t x);
		int unsigned acc;
		acc = 32'(old) * 32'(n) + 32'(x);
		return sample_t'(acc / (32'(n) + 32'd1));
	endfunction

	// Press test first, release test second: press wins when both hold
	function automatic logic next_flag(sample_t avg, logic flag);
		if (avg < prs_thresh)
			return 1'b0;
		if (avg > rel_thresh)
			return 1'b1;
		return flag;
	endfunction

	function automatic switch_report_t predict_switch_report(sample_t sec, sample_t cal,
			logic pos, logic start);
		switch_report_t r;
		logic [7:0]     win;
		logic           sec_pressed;
		logic           cal_pressed;
		win = (win_len == 8'd0) ? 8'd1 : win_len;
		r.trip        = 1'b0;
		r.window_done = 1'b0;

		// start_calibration goes first; safety stop ignores it
		if (start && m_mode != lsah_pkg::MODE_STOP)
			m_mode = lsah_pkg::MODE_CALIB;

		// a window shortened to the count or below restarts with this sample
		if (m_count >= win)
			m_count = 8'd0;
		m_sec_avg = next_mean(m_sec_avg, m_count, sec);
		m_cal_avg = next_mean(m_cal_avg, m_count, cal);
		m_count   = m_count + 8'd1;

		// window end: security line first, then calibration line
		if (m_count >= win) begin
			r.window_done = 1'b1;
			windows_seen++;
			sec_pressed = m_sec_avg < prs_thresh;
			m_sec_flag  = next_flag(m_sec_avg, m_sec_flag);
			if (sec_pressed && m_mode == lsah_pkg::MODE_SWEEP && pos) begin
				m_mode = lsah_pkg::MODE_STOP;
				r.trip = 1'b1;
				trips_seen++;
			end
			cal_pressed = m_cal_avg < prs_thresh;
			m_cal_flag  = next_flag(m_cal_avg, m_cal_flag);
			if (cal_pressed && m_mode == lsah_pkg::MODE_CALIB) begin
				m_mode = lsah_pkg::MODE_SWEEP;
				sweep_entries++;
			end
			m_count = 8'd0;
		end

		r.mode          = m_mode;
		r.security_ok   = m_sec_flag;
		r.calib_ok      = m_cal_flag;
		r.security_mean = m_sec_avg;
		r.calib_mean    = m_cal_avg;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------------

	task automatic report_mismatch(string what, int got, int want);
		if (errors < LOG_MAX)
			$display("%0t MISMATCH result %0d %s: got %0d, want %0d",
				$realtime, reports_checked, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin : check_results
		switch_report_t want;
		if (arst_n && out_valid && out_ready) begin
			if (reports_due.size() == 0) begin
				report_mismatch("result with nothing pending", 1, 0);
			end else begin
				want = reports_due.pop_front();
				if (mode != want.mode)
					report_mismatch("mode", mode, want.mode);
				if (security_ok != want.security_ok)
					report_mismatch("security_ok", security_ok, want.security_ok);
				if (calib_ok != want.calib_ok)
					report_mismatch("calib_ok", calib_ok, want.calib_ok);
				if (window_done != want.window_done)
					report_mismatch("window_done", window_done, want.window_done);
				if (trip != want.trip)
					report_mismatch("trip", trip, want.trip);
				if (security_mean != want.security_mean)
					report_mismatch("security_mean", security_mean, want.security_mean);
				if (calib_mean != want.calib_mean)
					report_mismatch("calib_mean", calib_mean, want.calib_mean);
				reports_checked++;
			end
		end
	end

	// Watchdog: cycles with no transfer on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles == STALL_MAX) begin
			$display("watchdog: no transfer for %0d cycles", STALL_MAX);
			$display("tb_top failed");
			$finish;
		end
	end

	// Receiver stalls at random, with a chance of about 17 percent, never while quiet
	always @(negedge clk) begin
		out_ready = quiet || ($urandom_range(99) >= 17);
	end

	// ------------------------------------------------------------------------
	// Driving tasks: entered and left at a falling edge
	// ------------------------------------------------------------------------

	task automatic send_pair(sample_t sec, sample_t cal, logic pos, logic start);
		switch_report_t want;
		while (!quiet && $urandom_range(99) < 17) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid          = 1'b1;
		security_sample   = sec;
		calib_sample      = cal;
		positioned        = pos;
		start_calibration = start;
		do @(posedge clk); while (!in_ready);
		want = predict_switch_report(sec, cal, pos, start);
		reports_due.push_back(want);
		pairs_sent++;
		@(negedge clk);
	endtask

	// Hold the sender until every pending result has been taken
	task automatic wait_drained();
		in_valid = 1'b0;
		while (reports_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_register(logic [lsah_pkg::CFG_INDEX_BITS-1:0] idx,
			logic [lsah_pkg::CFG_DATA_BITS-1:0] data);
		wait_drained();
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(negedge clk);
		cfg_write = 1'b0;
		case (idx)
			lsah_pkg::CFG_RELEASE: rel_thresh = data[11:0];
			lsah_pkg::CFG_PRESS:   prs_thresh = data[11:0];
			lsah_pkg::CFG_WINDOW:  win_len    = data[7:0];
			default: ;
		endcase
	endtask

	task automatic set_all(logic [11:0] rel, logic [11:0] prs, logic [7:0] win);
		set_register(lsah_pkg::CFG_RELEASE, rel);
		set_register(lsah_pkg::CFG_PRESS, prs);
		set_register(lsah_pkg::CFG_WINDOW, {4'h0, win});
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	task automatic apply_reset();
		arst_n            = 1'b0;
		quiet             = 1'b0;
		cfg_write         = 1'b0;
		cfg_index         = lsah_pkg::CFG_RELEASE;
		cfg_data          = '0;
		in_valid          = 1'b0;
		out_ready         = 1'b0;
		security_sample   = '0;
		calib_sample      = '0;
		positioned        = 1'b0;
		start_calibration = 1'b0;
		rel_thresh        = lsah_pkg::RELEASE_RST;
		prs_thresh        = lsah_pkg::PRESS_RST;
		win_len           = lsah_pkg::WINDOW_RST;
		m_count           = '0;
		m_sec_avg         = '0;
		m_cal_avg         = '0;
		m_sec_flag        = 1'b0;
		m_cal_flag        = 1'b0;
		m_mode            = lsah_pkg::MODE_CALIB;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	endtask

	// Field extremes and alternating bit patterns, one sample per window
	task automatic test_extremes();
		set_register(lsah_pkg::CFG_WINDOW, 12'd1);
		send_pair(12'd0, 12'd0, 1'b0, 1'b0);
		send_pair(12'hFFF, 12'hFFF, 1'b0, 1'b1);
		send_pair(12'hAAA, 12'h555, 1'b1, 1'b0);
		send_pair(12'h555, 12'hAAA, 1'b0, 1'b1);
		send_pair(12'hFFF, 12'd0, 1'b1, 1'b0);
	endtask

	// Exactly on and one past each threshold, and the hold band
	task automatic test_hysteresis_band();
		send_pair(12'd2501, 12'd2501, 1'b0, 1'b1);
		send_pair(12'd2500, 12'd1000, 1'b0, 1'b0);
		send_pair(12'd1000, 12'd999, 1'b0, 1'b0);
		send_pair(12'd999, 12'd2500, 1'b0, 1'b0);
		send_pair(12'd1500, 12'd1500, 1'b0, 1'b0);
		send_pair(12'd4095, 12'd4095, 1'b0, 1'b0);
	endtask

	// Release below press: the press test decides inside the overlap
	task automatic test_crossed_thresholds();
		set_register(lsah_pkg::CFG_RELEASE, 12'd1000);
		set_register(lsah_pkg::CFG_PRESS, 12'd3000);
		send_pair(12'd2000, 12'd2000, 1'b0, 1'b1);
		send_pair(12'd500, 12'd3500, 1'b0, 1'b0);
		send_pair(12'd3500, 12'd500, 1'b0, 1'b1);
	endtask

	// Window register zero acts as one; upper data bits are dropped
	task automatic test_window_zero();
		set_all(12'd2500, 12'd1000, 8'd1);
		set_register(lsah_pkg::CFG_WINDOW, 12'hF00);
		set_register(CFG_UNUSED, 12'hFFF);
		send_pair(12'd3000, 12'd300, 1'b0, 1'b0);
		send_pair(12'd700, 12'd3900, 1'b0, 1'b1);
	endtask

	// Shrink the window below the current count: it restarts on the next sample
	task automatic test_window_shrink();
		set_register(lsah_pkg::CFG_WINDOW, 12'd4);
		send_pair(12'd4000, 12'd100, 1'b0, 1'b0);
		send_pair(12'd3001, 12'd3333, 1'b0, 1'b0);
		send_pair(12'd17, 12'd2047, 1'b0, 1'b0);
		set_register(lsah_pkg::CFG_WINDOW, 12'd2);
		send_pair(12'd2048, 12'd4094, 1'b0, 1'b0);
		send_pair(12'd1, 12'd3, 1'b0, 1'b0);
	endtask

	function automatic sample_t pick_level();
		case ($urandom_range(3))
			0:       return sample_t'($urandom_range(700));
			1:       return sample_t'($urandom_range(SAMPLE_MAX, 3400));
			2:       return sample_t'($urandom_range(2400, 1200));
			default: return sample_t'($urandom_range(SAMPLE_MAX));
		endcase
	endfunction

	function automatic sample_t near_level(sample_t level);
		int v;
		v = int'(level) + int'($urandom_range(256)) - 128;
		if (v < 0)
			v = 0;
		if (v > SAMPLE_MAX)
			v = SAMPLE_MAX;
		return sample_t'(v);
	endfunction

	// Windows of samples held near a level per line, with noise and restarts.
	// Positioned stays low while sweeping so that no trip ends the run early.
	task automatic run_windows(logic [11:0] rel, logic [11:0] prs, logic [7:0] win, int count);
		sample_t sec_level;
		sample_t cal_level;
		sample_t sec;
		sample_t cal;
		logic    pos;
		logic    start;
		set_all(rel, prs, win);
		sec_level = pick_level();
		cal_level = pick_level();
		repeat (count) begin
			if (m_count == 8'd0 || $urandom_range(19) == 0) begin
				sec_level = pick_level();
				cal_level = pick_level();
			end
			if ($urandom_range(9) == 0) begin
				sec = sample_t'($urandom_range(SAMPLE_MAX));
				cal = sample_t'($urandom_range(SAMPLE_MAX));
			end else begin
				sec = near_level(sec_level);
				cal = near_level(cal_level);
			end
			start = ($urandom_range(39) == 0);
			pos   = (m_mode == lsah_pkg::MODE_SWEEP) ? 1'b0 : 1'($urandom_range(1));
			send_pair(sec, cal, pos, start);
		end
	endtask

	task automatic test_random_traffic();
		// no idling on either side for the first stretch
		quiet = 1'b1;
		run_windows(lsah_pkg::RELEASE_RST, lsah_pkg::PRESS_RST, lsah_pkg::WINDOW_RST, 300);
		quiet = 1'b0;
		run_windows(12'd2800, 12'd1200, 8'd3, 300);
		run_windows(12'd4095, 12'd0, 8'd7, 100);
		run_windows(12'd0, 12'd4095, 8'd2, 100);
		run_windows(12'd3000, 12'd800, 8'd1, 200);
		run_windows(12'd2000, 12'd1500, 8'd255, 300);
	endtask

	// Security press trips only while sweeping and positioned; the stop latches
	task automatic test_safety_stop();
		set_all(12'd2500, 12'd1000, 8'd1);
		send_pair(12'd4095, 12'd4095, 1'b0, 1'b1);
		send_pair(12'd0, 12'd4095, 1'b1, 1'b0);
		send_pair(12'd4095, 12'd0, 1'b1, 1'b0);
		send_pair(12'd0, 12'd4095, 1'b0, 1'b0);
		send_pair(12'd0, 12'd4095, 1'b1, 1'b0);
		send_pair(12'd4095, 12'd0, 1'b1, 1'b1);
		send_pair(12'd0, 12'd0, 1'b1, 1'b0);
	endtask

	initial begin
		errors          = 0;
		pairs_sent      = 0;
		reports_checked = 0;
		windows_seen    = 0;
		sweep_entries   = 0;
		trips_seen      = 0;
		idle_cycles     = 0;

		apply_reset();
		test_extremes();
		test_hysteresis_band();
		test_crossed_thresholds();
		test_window_zero();
		test_window_shrink();
		test_random_traffic();
		test_safety_stop();

		wait_drained();
		repeat (TAIL_WAIT) @(negedge clk);

		$display("Covered %0d sample pairs, %0d results checked, %0d windows closed,",
			pairs_sent, reports_checked, windows_seen);
		$display("%0d entries into sweeping and %0d trips, windows of 0 to 255 samples.",
			sweep_entries, trips_seen);
		if (errors == 0 && reports_due.size() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule
